FILE: rtl/hte_pkg.sv
// shared types and constants for the two-pass huffman encoder
// no dependencies; used by hte_ctrl, hte_dp and huffman_two_pass_encoder
`default_nettype none
package hte_pkg;

  localparam int ALPHABET_DEF   = 256;
  localparam int COUNT_BITS_DEF = 32;

  localparam logic [1:0] OPC_COUNT  = 2'd0;
  localparam logic [1:0] OPC_BUILD  = 2'd1;
  localparam logic [1:0] OPC_ENCODE = 2'd2;
  localparam logic [1:0] OPC_FLUSH  = 2'd3;

  localparam logic [1:0] KIND_CODE   = 2'd0;
  localparam logic [1:0] KIND_PAD    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_EMPTY   = 2'd1;
  localparam logic [1:0] ERR_NO_CODE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_C_RD, ST_C_WR,
    ST_B_CLR, ST_B_RD, ST_B_CHK, ST_B_END, ST_B_ONE,
    ST_S1_RD, ST_S1_CHK, ST_S2_RD, ST_S2_CHK, ST_J_L, ST_J_R,
    ST_SH_TEST, ST_SH_RD, ST_SH_WR, ST_SH_NEXT, ST_APPEND,
    ST_E_LEAF, ST_E_NODE, ST_E_RD, ST_E_STEP, ST_E_END,
    ST_F_BYTE, ST_F_PAD, ST_RESP_OK, ST_RESP_E1, ST_RESP_E2
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_C_RD, OP_C_WR,
    OP_B_CLR, OP_B_RD, OP_B_CHK, OP_B_END, OP_B_ONE,
    OP_Q_RD, OP_S1_CHK, OP_S2_CHK, OP_J_L, OP_J_R,
    OP_SH_RD, OP_SH_WR, OP_SH_NEXT, OP_APPEND,
    OP_E_LEAF, OP_E_NODE, OP_E_RD, OP_E_STEP, OP_E_END,
    OP_F_BYTE, OP_F_PAD, OP_RESP_OK, OP_RESP_E1, OP_RESP_E2
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic in_ok;
    logic enc_ok;
    logic scan_last;
    logic q_last;
    logic q_two;
    logic n_zero;
    logic n_one;
    logic sh_more;
    logic sh_second;
    logic walk_end;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/huffman_two_pass_encoder.sv
// a rejected count or encode returns only a status beat
// build scans the counts, then per merge finds the two lightest entries, joins them and shifts the queue
// throughput: one item at a time; the next is accepted in the cycle of the last beat
// results cannot be stalled; each one is shown for one cycle with strobe
// synchronous reset clears counts, tree, bit buffer and control
`default_nettype none
module huffman_two_pass_encoder #(
  parameter int ALPHABET   = hte_pkg::ALPHABET_DEF,
  parameter int COUNT_BITS = hte_pkg::COUNT_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] symbol,
  output logic            strobe,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic            last,
  output logic [1:0]      error
);

  hte_pkg::cmd_t    cmd;
  hte_pkg::status_t sts;

  hte_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  hte_dp #(
    .ALPHABET   (ALPHABET),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .symbol   (symbol),
    .sts      (sts),
    .strobe   (strobe),
    .out_byte (out_byte),
    .kind     (kind),
    .last     (last),
    .error    (error)
  );

`ifndef ASSERT_OFF
  a_done_beat: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe && last) else $error("item ended without final beat");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not start");
  a_pad_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == hte_pkg::KIND_PAD |-> last) else $error("pad beat not last");
  a_err_status: assert property (@(posedge clk) disable iff (rst)
    strobe && error != hte_pkg::ERR_NONE |-> last && kind == hte_pkg::KIND_STATUS)
    else $error("error on non-status beat");
`endif

endmodule
`default_nettype wire

FILE: rtl/hte_ctrl.sv
// sequencing state machine for the huffman encoder
// depends on hte_pkg; drives hte_dp through cmd_t and reads status_t
`default_nettype none
module hte_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [1:0]      opcode,
  input  wire hte_pkg::status_t sts,
  output hte_pkg::cmd_t        cmd,
  output logic                 busy
);

  hte_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hte_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hte_pkg::ST_IDLE: begin
        if (start) begin
          case (opcode)
            hte_pkg::OPC_COUNT:
              state_next = sts.in_ok ? hte_pkg::ST_C_RD : hte_pkg::ST_RESP_E2;
            hte_pkg::OPC_BUILD:  state_next = hte_pkg::ST_B_CLR;
            hte_pkg::OPC_ENCODE:
              state_next = sts.enc_ok ? hte_pkg::ST_E_LEAF : hte_pkg::ST_RESP_E2;
            hte_pkg::OPC_FLUSH:  state_next = hte_pkg::ST_F_BYTE;
            default:             state_next = hte_pkg::ST_IDLE;
          endcase
        end
      end
      hte_pkg::ST_C_RD:    state_next = hte_pkg::ST_C_WR;
      hte_pkg::ST_C_WR:    state_next = hte_pkg::ST_IDLE;
      hte_pkg::ST_B_CLR:   state_next = hte_pkg::ST_B_RD;
      hte_pkg::ST_B_RD:    state_next = hte_pkg::ST_B_CHK;
      hte_pkg::ST_B_CHK:
        state_next = sts.scan_last ? hte_pkg::ST_B_END : hte_pkg::ST_B_RD;
      hte_pkg::ST_B_END: begin
        if (sts.n_zero) begin
          state_next = hte_pkg::ST_RESP_E1;
        end else if (sts.n_one) begin
          state_next = hte_pkg::ST_B_ONE;
        end else begin
          state_next = hte_pkg::ST_S1_RD;
        end
      end
      hte_pkg::ST_B_ONE:   state_next = hte_pkg::ST_RESP_OK;
      hte_pkg::ST_S1_RD:   state_next = hte_pkg::ST_S1_CHK;
      hte_pkg::ST_S1_CHK: begin
        if (!sts.q_last) begin
          state_next = hte_pkg::ST_S1_RD;
        end else if (sts.q_two) begin
          state_next = hte_pkg::ST_J_L;
        end else begin
          state_next = hte_pkg::ST_S2_RD;
        end
      end
      hte_pkg::ST_S2_RD:   state_next = hte_pkg::ST_S2_CHK;
      hte_pkg::ST_S2_CHK:
        state_next = sts.q_last ? hte_pkg::ST_J_L : hte_pkg::ST_S2_RD;
      hte_pkg::ST_J_L:     state_next = hte_pkg::ST_J_R;
      hte_pkg::ST_J_R:
        state_next = sts.q_two ? hte_pkg::ST_RESP_OK : hte_pkg::ST_SH_TEST;
      hte_pkg::ST_SH_TEST: begin
        if (sts.sh_more) begin
          state_next = hte_pkg::ST_SH_RD;
        end else if (sts.sh_second) begin
          state_next = hte_pkg::ST_APPEND;
        end else begin
          state_next = hte_pkg::ST_SH_NEXT;
        end
      end
      hte_pkg::ST_SH_RD:   state_next = hte_pkg::ST_SH_WR;
      hte_pkg::ST_SH_WR:   state_next = hte_pkg::ST_SH_TEST;
      hte_pkg::ST_SH_NEXT: state_next = hte_pkg::ST_SH_TEST;
      hte_pkg::ST_APPEND:  state_next = hte_pkg::ST_S1_RD;
      hte_pkg::ST_E_LEAF:  state_next = hte_pkg::ST_E_NODE;
      hte_pkg::ST_E_NODE:  state_next = hte_pkg::ST_E_RD;
      hte_pkg::ST_E_RD:    state_next = hte_pkg::ST_E_STEP;
      hte_pkg::ST_E_STEP:
        state_next = sts.walk_end ? hte_pkg::ST_E_END : hte_pkg::ST_E_RD;
      hte_pkg::ST_E_END:   state_next = hte_pkg::ST_IDLE;
      hte_pkg::ST_F_BYTE:  state_next = hte_pkg::ST_F_PAD;
      hte_pkg::ST_F_PAD:   state_next = hte_pkg::ST_IDLE;
      hte_pkg::ST_RESP_OK: state_next = hte_pkg::ST_IDLE;
      hte_pkg::ST_RESP_E1: state_next = hte_pkg::ST_IDLE;
      hte_pkg::ST_RESP_E2: state_next = hte_pkg::ST_IDLE;
      default:             state_next = hte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != hte_pkg::ST_IDLE);
    cmd.op = hte_pkg::OP_NONE;
    case (state)
      hte_pkg::ST_IDLE:    cmd.op = start ? hte_pkg::OP_ACCEPT : hte_pkg::OP_NONE;
      hte_pkg::ST_C_RD:    cmd.op = hte_pkg::OP_C_RD;
      hte_pkg::ST_C_WR:    cmd.op = hte_pkg::OP_C_WR;
      hte_pkg::ST_B_CLR:   cmd.op = hte_pkg::OP_B_CLR;
      hte_pkg::ST_B_RD:    cmd.op = hte_pkg::OP_B_RD;
      hte_pkg::ST_B_CHK:   cmd.op = hte_pkg::OP_B_CHK;
      hte_pkg::ST_B_END:   cmd.op = hte_pkg::OP_B_END;
      hte_pkg::ST_B_ONE:   cmd.op = hte_pkg::OP_B_ONE;
      hte_pkg::ST_S1_RD:   cmd.op = hte_pkg::OP_Q_RD;
      hte_pkg::ST_S1_CHK:  cmd.op = hte_pkg::OP_S1_CHK;
      hte_pkg::ST_S2_RD:   cmd.op = hte_pkg::OP_Q_RD;
      hte_pkg::ST_S2_CHK:  cmd.op = hte_pkg::OP_S2_CHK;
      hte_pkg::ST_J_L:     cmd.op = hte_pkg::OP_J_L;
      hte_pkg::ST_J_R:     cmd.op = hte_pkg::OP_J_R;
      hte_pkg::ST_SH_TEST: cmd.op = hte_pkg::OP_NONE;
      hte_pkg::ST_SH_RD:   cmd.op = hte_pkg::OP_SH_RD;
      hte_pkg::ST_SH_WR:   cmd.op = hte_pkg::OP_SH_WR;
      hte_pkg::ST_SH_NEXT: cmd.op = hte_pkg::OP_SH_NEXT;
      hte_pkg::ST_APPEND:  cmd.op = hte_pkg::OP_APPEND;
      hte_pkg::ST_E_LEAF:  cmd.op = hte_pkg::OP_E_LEAF;
      hte_pkg::ST_E_NODE:  cmd.op = hte_pkg::OP_E_NODE;
      hte_pkg::ST_E_RD:    cmd.op = hte_pkg::OP_E_RD;
      hte_pkg::ST_E_STEP:  cmd.op = hte_pkg::OP_E_STEP;
      hte_pkg::ST_E_END:   cmd.op = hte_pkg::OP_E_END;
      hte_pkg::ST_F_BYTE:  cmd.op = hte_pkg::OP_F_BYTE;
      hte_pkg::ST_F_PAD:   cmd.op = hte_pkg::OP_F_PAD;
      hte_pkg::ST_RESP_OK: cmd.op = hte_pkg::OP_RESP_OK;
      hte_pkg::ST_RESP_E1: cmd.op = hte_pkg::OP_RESP_E1;
      hte_pkg::ST_RESP_E2: cmd.op = hte_pkg::OP_RESP_E2;
      default:             cmd.op = hte_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/hte_dp.sv
// datapath of the huffman encoder: counts, work queue, tree and bit packer
// depends on hte_pkg; sequenced by hte_ctrl
`default_nettype none
module hte_dp #(
  parameter int ALPHABET   = hte_pkg::ALPHABET_DEF,
  parameter int COUNT_BITS = hte_pkg::COUNT_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hte_pkg::cmd_t    cmd,
  input  wire logic [7:0]       symbol,
  output hte_pkg::status_t      sts,
  output logic                  strobe,
  output logic [7:0]            out_byte,
  output logic [1:0]            kind,
  output logic                  last,
  output logic [1:0]            error
);

  localparam int AW    = $clog2(ALPHABET);
  localparam int IW    = AW + 1;
  localparam int NW    = AW + 1;
  localparam int NODES = 2 * ALPHABET - 1;
  localparam int CB    = COUNT_BITS;
  localparam logic [CB-1:0] CMAX = '1;

  logic [CB-1:0]       cnt_mem [ALPHABET];
  logic [ALPHABET-1:0] cvalid;
  logic [CB-1:0]       cnt_rd;
  logic                cv_rd;
  logic [NW-1:0]       leaf_mem [ALPHABET];
  logic [ALPHABET-1:0] lvalid;
  logic [NW-1:0]       leaf_rd;
  logic [NW+CB-1:0]    q_mem [ALPHABET];
  logic [NW+CB-1:0]    q_rd;
  logic [NW:0]         tr_mem [NODES];
  logic [NW:0]         tr_rd;

  logic [7:0]    sym_r;
  logic [IW-1:0] i, q, n;
  logic [NW-1:0] next_node, root, node, na, nb;
  logic [AW-1:0] a, b, lo;
  logic [CB-1:0] wa, wb;
  logic          tree_valid, sh_second;
  logic [7:0]    buffer, pend;
  logic          pend_v;
  logic [3:0]    fill;
  logic [7:0]    steps;

  logic [CB-1:0] cnt_val, rd_w;
  logic [NW-1:0] rd_n, tr_parent;
  logic          tr_side;
  logic [CB:0]   wsum;
  logic [CB-1:0] wsat;
  logic [AW-1:0] sym_idx, in_idx, q_ra, q_wa;
  logic          q_we;
  logic [NW+CB-1:0] q_wd;
  hte_pkg::dp_op_t op;

  always_comb begin
    op        = cmd.op;
    sym_idx   = sym_r[AW-1:0];
    in_idx    = symbol[AW-1:0];
    cnt_val   = cv_rd ? cnt_rd : '0;
    rd_n      = q_rd[NW+CB-1:CB];
    rd_w      = q_rd[CB-1:0];
    tr_parent = tr_rd[NW:1];
    tr_side   = tr_rd[0];
    wsum      = {1'b0, wa} + {1'b0, wb};
    wsat      = wsum[CB] ? CMAX : wsum[CB-1:0];
    sts.in_ok     = ({1'b0, symbol} < 9'(ALPHABET));
    sts.enc_ok    = sts.in_ok && tree_valid && lvalid[in_idx];
    sts.scan_last = (i == IW'(ALPHABET - 1));
    sts.q_last    = (i == q - IW'(1));
    sts.q_two     = (q == IW'(2));
    sts.n_zero    = (n == '0);
    sts.n_one     = (n == IW'(1));
    sts.sh_more   = ((i + IW'(1)) < q);
    sts.sh_second = sh_second;
    sts.walk_end  = (tr_parent == root) || (steps == 8'd254);
  end

  // work queue port selection
  always_comb begin
    q_ra = (op == hte_pkg::OP_SH_RD) ? AW'(i + IW'(1)) : i[AW-1:0];
    q_we = 1'b0;
    q_wa = i[AW-1:0];
    q_wd = q_rd;
    case (op)
      hte_pkg::OP_B_CHK: begin
        q_we = (cnt_val != '0);
        q_wa = n[AW-1:0];
        q_wd = {n, cnt_val};
      end
      hte_pkg::OP_SH_WR: begin
        q_we = 1'b1;
      end
      hte_pkg::OP_APPEND: begin
        q_we = 1'b1;
        q_wa = AW'(q - IW'(2));
        q_wd = {next_node, wsat};
      end
      default: q_we = 1'b0;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (op == hte_pkg::OP_C_RD || op == hte_pkg::OP_B_RD) begin
      cnt_rd <= cnt_mem[(op == hte_pkg::OP_C_RD) ? sym_idx : i[AW-1:0]];
      cv_rd  <= cvalid[(op == hte_pkg::OP_C_RD) ? sym_idx : i[AW-1:0]];
    end
    if (op == hte_pkg::OP_C_WR) begin
      cnt_mem[sym_idx] <= (cnt_val == CMAX) ? cnt_val : cnt_val + CB'(1);
    end
    if (op == hte_pkg::OP_B_CHK && cnt_val != '0) begin
      leaf_mem[i[AW-1:0]] <= n;
    end
    if (op == hte_pkg::OP_E_LEAF) begin
      leaf_rd <= leaf_mem[sym_idx];
    end
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    if (op == hte_pkg::OP_Q_RD || op == hte_pkg::OP_SH_RD) begin
      q_rd <= q_mem[q_ra];
    end
    case (op)
      hte_pkg::OP_B_ONE: tr_mem[NW'(0)] <= {NW'(1), 1'b0};
      hte_pkg::OP_J_L:   tr_mem[na] <= {next_node, 1'b0};
      hte_pkg::OP_J_R:   tr_mem[nb] <= {next_node, 1'b1};
      hte_pkg::OP_E_RD:  tr_rd <= tr_mem[node];
      default: ;
    endcase
  end

  // valid bits and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid     <= '0;
      lvalid     <= '0;
      tree_valid <= 1'b0;
      buffer     <= '0;
      fill       <= '0;
      pend_v     <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (op)
        hte_pkg::OP_ACCEPT: begin
          sym_r  <= symbol;
          pend_v <= 1'b0;
        end
        hte_pkg::OP_C_WR: begin
          cvalid[sym_idx] <= 1'b1;
          strobe   <= 1'b1;
          out_byte <= '0;
          kind     <= hte_pkg::KIND_STATUS;
          last     <= 1'b1;
          error    <= hte_pkg::ERR_NONE;
        end
        hte_pkg::OP_B_CLR: begin
          lvalid     <= '0;
          tree_valid <= 1'b0;
          i          <= '0;
          n          <= '0;
        end
        hte_pkg::OP_B_CHK: begin
          if (cnt_val != '0) begin
            lvalid[i[AW-1:0]] <= 1'b1;
            n <= n + IW'(1);
          end
          i <= i + IW'(1);
        end
        hte_pkg::OP_B_END: begin
          q         <= n;
          next_node <= n;
          i         <= '0;
        end
        hte_pkg::OP_B_ONE: begin
          root       <= NW'(1);
          tree_valid <= 1'b1;
        end
        hte_pkg::OP_S1_CHK: begin
          if (i == '0 || (rd_w < wa && i != IW'(1))) begin
            a  <= i[AW-1:0];
            wa <= rd_w;
            na <= rd_n;
          end
          if (i == IW'(1)) begin
            b  <= AW'(1);
            wb <= rd_w;
            nb <= rd_n;
          end
          i <= sts.q_last ? '0 : i + IW'(1);
        end
        hte_pkg::OP_S2_CHK: begin
          if (rd_w < wb && i[AW-1:0] != a) begin
            b  <= i[AW-1:0];
            wb <= rd_w;
            nb <= rd_n;
          end
          i <= i + IW'(1);
        end
        hte_pkg::OP_J_R: begin
          if (sts.q_two) begin
            root       <= next_node;
            tree_valid <= 1'b1;
          end
          i         <= IW'((a > b) ? a : b);
          lo        <= (a > b) ? b : a;
          sh_second <= 1'b0;
        end
        hte_pkg::OP_SH_WR: i <= i + IW'(1);
        hte_pkg::OP_SH_NEXT: begin
          i         <= IW'(lo);
          sh_second <= 1'b1;
        end
        hte_pkg::OP_APPEND: begin
          q         <= q - IW'(1);
          next_node <= next_node + NW'(1);
          i         <= '0;
        end
        hte_pkg::OP_E_NODE: begin
          node  <= leaf_rd;
          steps <= '0;
        end
        hte_pkg::OP_E_STEP: begin
          if (fill == 4'd8) begin
            if (pend_v) begin
              strobe   <= 1'b1;
              out_byte <= pend;
              kind     <= hte_pkg::KIND_CODE;
              last     <= 1'b0;
              error    <= hte_pkg::ERR_NONE;
            end
            pend   <= buffer;
            pend_v <= 1'b1;
            buffer <= {7'd0, tr_side};
            fill   <= 4'd1;
          end else begin
            buffer <= buffer | (8'(tr_side) << fill[2:0]);
            fill   <= fill + 4'd1;
          end
          node  <= tr_parent;
          steps <= steps + 8'd1;
        end
        hte_pkg::OP_E_END: begin
          strobe   <= 1'b1;
          out_byte <= pend_v ? pend : 8'd0;
          kind     <= pend_v ? hte_pkg::KIND_CODE : hte_pkg::KIND_STATUS;
          last     <= 1'b1;
          error    <= hte_pkg::ERR_NONE;
          pend_v   <= 1'b0;
        end
        hte_pkg::OP_F_BYTE: begin
          strobe   <= 1'b1;
          out_byte <= buffer;
          kind     <= hte_pkg::KIND_CODE;
          last     <= 1'b0;
          error    <= hte_pkg::ERR_NONE;
        end
        hte_pkg::OP_F_PAD: begin
          strobe   <= 1'b1;
          out_byte <= 8'(4'd8 - fill);
          kind     <= hte_pkg::KIND_PAD;
          last     <= 1'b1;
          error    <= hte_pkg::ERR_NONE;
          buffer   <= '0;
          fill     <= '0;
        end
        hte_pkg::OP_RESP_OK, hte_pkg::OP_RESP_E1, hte_pkg::OP_RESP_E2: begin
          strobe   <= 1'b1;
          out_byte <= '0;
          kind     <= hte_pkg::KIND_STATUS;
          last     <= 1'b1;
          error    <= (op == hte_pkg::OP_RESP_E1) ? hte_pkg::ERR_EMPTY :
                      (op == hte_pkg::OP_RESP_E2) ? hte_pkg::ERR_NO_CODE :
                      hte_pkg::ERR_NONE;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
